// ===== src/mft_pkg.sv =====
// shared types and codes for the multi-turn feedback tracker
`default_nettype none
package mft_pkg;

	localparam logic MODE_FRAME = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [1:0] motor_index;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
		logic [7:0] byte5;
		logic [7:0] byte6;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         which_motor;
		logic [15:0]        shaft_angle;
		logic signed [15:0] shaft_speed;
		logic signed [15:0] measured_current;
		logic [7:0]         temperature;
		logic signed [31:0] position;
		logic               first_sample;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic [15:0]        angle;
	} track_ent_t;

endpackage
`default_nettype wire

// ===== src/mft_if.sv =====
// handshake channels for input frames and result words
`default_nettype none
interface mft_in_if import mft_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mft_out_if import mft_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mft_track_mem.sv =====
// per-motor tracker store: synchronous entry memory plus started flags
`default_nettype none
module mft_track_mem import mft_pkg::*; #(
	parameter int NUM_MOTORS = 4,
	parameter int IDX_W = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_idx,
	output track_ent_t            rd_ent,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire track_ent_t       wr_ent,
	input  wire logic [IDX_W-1:0] st_idx,
	input  wire logic             set_en,
	input  wire logic             clr_en,
	output logic                  started
);

	track_ent_t mem [NUM_MOTORS];
	track_ent_t rd_q;
	logic [NUM_MOTORS-1:0] started_q;

	// read during write to the same entry takes the new word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_ent;
		end
		if (rd_en) begin
			if (wr_en && wr_idx == rd_idx) begin
				rd_q <= wr_ent;
			end else begin
				rd_q <= mem[rd_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
		end else if (set_en) begin
			started_q[st_idx] <= 1'b1;
		end else if (clr_en) begin
			started_q[st_idx] <= 1'b0;
		end
	end

	assign rd_ent  = rd_q;
	assign started = started_q[st_idx];

	a_set_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		set_en |=> started_q[$past(st_idx)])
		else $error("started flag not set after frame");
	a_clr_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_en && !set_en |=> !started_q[$past(st_idx)])
		else $error("started flag not cleared after reset request");
	a_wr_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> set_en && wr_idx == st_idx)
		else $error("entry write without started update");

endmodule
`default_nettype wire

// ===== src/mft_unwrap.sv =====
// angle difference folding and position accumulate
`default_nettype none
module mft_unwrap #(
	parameter int TICKS_PER_TURN = 8192
) (
	input  wire logic [15:0]        angle,
	input  wire logic [15:0]        prev_angle,
	input  wire logic signed [31:0] pos,
	output logic signed [31:0]      new_pos
);

	localparam logic signed [18:0] HALF_C = 19'(TICKS_PER_TURN / 2);
	localparam logic signed [18:0] TURN_C = 19'(TICKS_PER_TURN);

	logic signed [18:0] diff;
	logic signed [18:0] fold;

	always_comb begin
		diff = $signed({3'b000, angle}) - $signed({3'b000, prev_angle});
		priority if (diff > HALF_C) begin
			fold = diff - TURN_C;
		end else if (diff < -HALF_C) begin
			fold = diff + TURN_C;
		end else begin
			fold = diff;
		end
		new_pos = pos + $signed({{13{fold[18]}}, fold});
	end

endmodule
`default_nettype wire

// ===== src/motor_feedback_multiturn_tracker.sv =====
// top level of the multi-turn motor feedback tracker
//
// frame channel: one word per motor feedback frame or tracker reset request
// (mode = 1). result channel: one word per feedback frame for a motor index
// below NUM_MOTORS, carrying the decoded angle, speed, current, temperature
// and the multi-turn position after that frame. reset requests and frames
// for motors that do not exist give no result word.
// pipeline: an accepted word and its entry read are registered together, and
// the update from them is then written into the output register.
// throughput: one word per cycle unless stalled, set by the single
// read-modify-write of the per-motor entry memory; a read of an entry being
// written is forwarded, so one motor's back-to-back frames run at full rate.
// reset: all motors start untracked; the first frame of each motor gives
// position zero with first_sample set. a held result stalls the update
// stage and frame.ready falls only while the output register is full and
// result.ready is low.
`default_nettype none
module motor_feedback_multiturn_tracker import mft_pkg::*; #(
	parameter int NUM_MOTORS = 4,
	parameter int TICKS_PER_TURN = 8192
) (
	input wire logic clk,
	input wire logic arst_n,
	mft_in_if.sink   frame,
	mft_out_if.source result
);

	localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

	logic             accept;
	logic             in_rng;
	logic             vld_s1;
	logic             rng_s1;
	in_word_t         word_s1;
	logic             res_s1;
	logic             clr_s1;
	logic             go_s1;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] idx_s1;
	track_ent_t       rd_ent;
	track_ent_t       wr_ent;
	logic             started;
	logic             wr_en;
	logic [15:0]      angle_s1;
	logic signed [31:0] new_pos;
	logic             out_vld_q;
	out_word_t        out_q;

	assign in_rng = {30'd0, frame.data.motor_index} < 32'(NUM_MOTORS);
	assign accept = frame.valid && frame.ready;
	assign rd_idx = IDX_W'(frame.data.motor_index);
	assign idx_s1 = IDX_W'(word_s1.motor_index);

	assign res_s1 = vld_s1 && rng_s1 && word_s1.mode == MODE_FRAME;
	assign clr_s1 = vld_s1 && rng_s1 && word_s1.mode == MODE_CLEAR;
	assign go_s1  = !res_s1 || !out_vld_q || result.ready;
	assign wr_en  = res_s1 && go_s1;
	assign frame.ready = !vld_s1 || go_s1;

	assign angle_s1 = {word_s1.byte0, word_s1.byte1};

	mft_track_mem #(
		.NUM_MOTORS(NUM_MOTORS),
		.IDX_W     (IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept && in_rng),
		.rd_idx (rd_idx),
		.rd_ent (rd_ent),
		.wr_en  (wr_en),
		.wr_idx (idx_s1),
		.wr_ent (wr_ent),
		.st_idx (idx_s1),
		.set_en (wr_en),
		.clr_en (clr_s1),
		.started(started)
	);

	mft_unwrap #(
		.TICKS_PER_TURN(TICKS_PER_TURN)
	) u_unwrap (
		.angle     (angle_s1),
		.prev_angle(rd_ent.angle),
		.pos       (rd_ent.pos),
		.new_pos   (new_pos)
	);

	assign wr_ent = '{pos: (started ? new_pos : 32'sd0), angle: angle_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (frame.ready) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= frame.data;
			rng_s1  <= in_rng;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (wr_en) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_q.which_motor      <= word_s1.motor_index;
			out_q.shaft_angle      <= angle_s1;
			out_q.shaft_speed      <= $signed({word_s1.byte2, word_s1.byte3});
			out_q.measured_current <= $signed({word_s1.byte4, word_s1.byte5});
			out_q.temperature      <= word_s1.byte6;
			out_q.position         <= wr_ent.pos;
			out_q.first_sample     <= !started;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.first_sample |-> result.data.position == 32'sd0)
		else $error("first word with non-zero position");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1 && out_vld_q && !result.ready |-> !frame.ready)
		else $error("frame taken while update stage is blocked");
	a_no_clr_result: assert property (@(posedge clk) disable iff (!arst_n)
		clr_s1 |=> out_vld_q == $past(out_vld_q && !result.ready))
		else $error("reset request produced a result word");

endmodule
`default_nettype wire

// ===== test/tb_motor_feedback_multiturn_tracker.sv =====
// self-checking testbench for the multi-turn motor feedback tracker
`timescale 1ns / 100ps
module tb_motor_feedback_multiturn_tracker;
	import mft_pkg::*;

	localparam int MOTORS = 4;
	localparam int TURN = 8192;
	localparam int HALF_TURN = TURN / 2;
	localparam int SPIN_FRAMES = 40;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 50000;

	logic clk;
	logic arst_n;

	mft_in_if frame ();
	mft_out_if result ();

	motor_feedback_multiturn_tracker #(
		.NUM_MOTORS(MOTORS),
		.TICKS_PER_TURN(TURN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame),
		.result(result)
	);

	in_word_t frames_to_send[$];
	out_word_t predicted_feedback[$];

	logic signed [31:0] trk_pos[MOTORS];
	logic [15:0] trk_prev[MOTORS];
	logic trk_live[MOTORS];
	logic [15:0] gen_prev[MOTORS];

	int send_idle_pct;
	int recv_stall_pct;
	logic holding;
	logic hold_go;
	int errors;
	int n_frames;
	int n_clears;
	int n_checked;
	int cycle_count;
	out_word_t want_word;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic track_word(input in_word_t w);
		logic [15:0] ang;
		int step;
		out_word_t r;
		if (w.mode == MODE_CLEAR) begin
			trk_pos[w.motor_index] = '0;
			trk_prev[w.motor_index] = '0;
			trk_live[w.motor_index] = 1'b0;
			n_clears++;
		end else begin
			ang = {w.byte0, w.byte1};
			r.first_sample = !trk_live[w.motor_index];
			if (!trk_live[w.motor_index]) begin
				trk_live[w.motor_index] = 1'b1;
				trk_pos[w.motor_index] = '0;
			end else begin
				step = int'(ang) - int'(trk_prev[w.motor_index]);
				if (step > HALF_TURN)
					step -= TURN;
				else if (step < -HALF_TURN)
					step += TURN;
				trk_pos[w.motor_index] = trk_pos[w.motor_index] + step;
			end
			trk_prev[w.motor_index] = ang;
			r.which_motor = w.motor_index;
			r.shaft_angle = ang;
			r.shaft_speed = {w.byte2, w.byte3};
			r.measured_current = {w.byte4, w.byte5};
			r.temperature = w.byte6;
			r.position = trk_pos[w.motor_index];
			predicted_feedback.push_back(r);
			n_frames++;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// driver: one word offered at a time, held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame.valid && frame.ready)
				track_word(frame.data);
			if (!frame.valid || frame.ready) begin
				if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					frame.valid <= 1'b1;
					frame.data <= frames_to_send.pop_front();
				end else begin
					frame.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (predicted_feedback.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					want_word = predicted_feedback.pop_front();
					check_field("which_motor", want_word.which_motor, result.data.which_motor);
					check_field("shaft_angle", want_word.shaft_angle, result.data.shaft_angle);
					check_field("shaft_speed", want_word.shaft_speed, result.data.shaft_speed);
					check_field("measured_current", want_word.measured_current,
						result.data.measured_current);
					check_field("temperature", want_word.temperature, result.data.temperature);
					check_field("position", want_word.position, result.data.position);
					check_field("first_sample", want_word.first_sample,
						result.data.first_sample);
					n_checked++;
				end
			end
			result.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off
	initial begin
		holding = 1'b0;
		wait (hold_go);
		@(posedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic in_word_t make_frame(input logic [1:0] m, input logic [15:0] ang,
			input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] temp);
		in_word_t w;
		w.mode = MODE_FRAME;
		w.motor_index = m;
		{w.byte0, w.byte1} = ang;
		{w.byte2, w.byte3} = spd;
		{w.byte4, w.byte5} = cur;
		w.byte6 = temp;
		return w;
	endfunction

	function automatic in_word_t make_clear(input logic [1:0] m);
		in_word_t w;
		w = in_word_t'(59'({$urandom, $urandom}));
		w.mode = MODE_CLEAR;
		w.motor_index = m;
		return w;
	endfunction

	task automatic offer(input in_word_t w);
		while (frames_to_send.size() >= 16)
			@(negedge clk);
		frames_to_send.push_back(w);
	endtask

	task automatic offer_frame(input logic [1:0] m, input logic [15:0] ang);
		offer(make_frame(m, ang, 16'($urandom), 16'($urandom), 8'($urandom)));
		gen_prev[m] = ang;
	endtask

	task automatic offer_random();
		logic [1:0] m;
		logic [15:0] ang;
		int pick;
		m = 2'($urandom_range(MOTORS - 1));
		if ($urandom_range(99) < 8) begin
			offer(make_clear(m));
		end else begin
			pick = $urandom_range(9);
			if (pick <= 3)
				ang = 16'(int'(gen_prev[m]) + $urandom_range(800) - 400);
			else if (pick == 4)
				case ($urandom_range(5))
					0: ang = gen_prev[m] + 16'(HALF_TURN);
					1: ang = gen_prev[m] - 16'(HALF_TURN);
					2: ang = gen_prev[m] + 16'(HALF_TURN + 1);
					3: ang = gen_prev[m] - 16'(HALF_TURN + 1);
					4: ang = gen_prev[m] + 16'(HALF_TURN - 1);
					default: ang = gen_prev[m] - 16'(HALF_TURN - 1);
				endcase
			else if (pick <= 6)
				ang = 16'($urandom_range(TURN - 1));
			else if (pick <= 8)
				ang = 16'($urandom);
			else
				case ($urandom_range(3))
					0: ang = 16'h0000;
					1: ang = 16'hffff;
					2: ang = 16'(TURN - 1);
					default: ang = 16'(TURN);
				endcase
			offer_frame(m, ang);
		end
	endtask

	task automatic drain();
		while (frames_to_send.size() != 0 || frame.valid || predicted_feedback.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		logic [15:0] ang;
		errors = 0;
		n_frames = 0;
		n_clears = 0;
		n_checked = 0;
		cycle_count = 0;
		hold_go = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < MOTORS; i++) begin
			trk_pos[i] = '0;
			trk_prev[i] = '0;
			trk_live[i] = 1'b0;
			gen_prev[i] = '0;
		end
		arst_n = 1'b0;
		frame.valid = 1'b0;
		frame.data = '0;
		result.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, fold edges, clears
		set_idling(0, 0);
		offer(make_frame(2'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
		offer(make_frame(2'd0, 16'hffff, 16'hffff, 16'hffff, 8'hff));
		offer(make_frame(2'd0, 16'h0000, 16'h8000, 16'h7fff, 8'h80));
		offer(make_frame(2'd0, 16'(HALF_TURN), 16'h7fff, 16'h8000, 8'h7f));
		offer(make_frame(2'd0, 16'h0000, 16'h0001, 16'hfffe, 8'h01));
		offer(make_frame(2'd0, 16'(HALF_TURN + 1), 16'h1234, 16'h5678, 8'h9a));
		offer(make_frame(2'd0, 16'h0000, 16'hedcb, 16'ha987, 8'h65));
		offer(make_frame(2'd0, 16'(TURN - 1), 16'h0100, 16'h00ff, 8'h10));
		offer(make_frame(2'd0, 16'h0001, 16'hff00, 16'h0100, 8'hef));
		offer(make_frame(2'd1, 16'(TURN - 1), 16'h7fff, 16'h8000, 8'h00));
		offer(make_frame(2'd1, 16'(TURN - 1), 16'h8000, 16'h7fff, 8'hff));
		offer(make_clear(2'd0));
		offer(make_frame(2'd0, 16'd1234, 16'h0000, 16'hffff, 8'h42));
		offer(make_clear(2'd2));
		offer(make_frame(2'd2, 16'hffff, 16'h5555, 16'haaaa, 8'h55));
		offer(make_frame(2'd3, 16'h55aa, 16'h55aa, 16'h55aa, 8'haa));
		offer(make_frame(2'd3, 16'haa55, 16'haa55, 16'haa55, 8'h55));
		offer(make_clear(2'd1));
		offer(make_clear(2'd1));
		offer(make_frame(2'd1, 16'h2000, 16'h0000, 16'h0000, 8'h00));
		offer(make_frame(2'd1, 16'h0fff, 16'hffff, 16'hffff, 8'hff));
		drain();

		// spin one motor forward in near half-turn steps
		offer(make_clear(2'd3));
		ang = '0;
		for (int i = 0; i < SPIN_FRAMES; i++) begin
			offer(make_frame(2'd3, ang, 16'($urandom), 16'($urandom), 8'($urandom)));
			ang = (ang >= 16'(HALF_TURN + 1)) ? ang - 16'(HALF_TURN + 1)
				: ang + 16'(HALF_TURN - 1);
		end
		gen_prev[3] = ang;
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_idling(0, 0);
				1: set_idling(70, 0);
				2: set_idling(0, 70);
				default: set_idling(26, 26);
			endcase
			repeat (RANDOM_PER_PHASE) offer_random();
			drain();
		end

		// input back-pressure while the receiver holds off
		set_idling(0, 0);
		hold_go = 1'b1;
		repeat (40) offer_random();
		drain();

		repeat (10) @(posedge clk);
		if (predicted_feedback.size() != 0) begin
			$error("%0d expected result words never arrived", predicted_feedback.size());
			errors++;
		end
		$display("covered %0d feedback frames and %0d tracker clears, %0d results checked",
			n_frames, n_clears, n_checked);
		$display("including a %0d-frame forward spin and a %0d-cycle receiver hold-off",
			SPIN_FRAMES, HOLD_CYCLES);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
